FILE: src/xssl_pkg.sv
// ============================================================================
// xssl_pkg - segment stream loader shared definitions
// Word formats, parser phases, error codes and register indexes.
// ============================================================================
package xssl_pkg;

    localparam int ADDR_W    = 16;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 4;

    localparam logic [BYTE_W-1:0] HDR_BYTE   = 8'hFF;
    localparam logic [ADDR_W-1:0] SEG_MARKER = 16'hFFFF;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_EOF  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_INIT_VEC = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RUN_VEC  = 4'd1;

    localparam logic [ADDR_W-1:0] INIT_VEC_RST = 16'd738;
    localparam logic [ADDR_W-1:0] RUN_VEC_RST  = 16'd736;

    typedef enum logic [3:0] {
        PH_HDR0,
        PH_HDR1,
        PH_START_LO,
        PH_START_HI,
        PH_START2_LO,
        PH_START2_HI,
        PH_END_LO,
        PH_END_HI,
        PH_DATA,
        PH_ERROR
    } phase_t;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_SHORT_HDR,
        ERR_BAD_HDR,
        ERR_END_CUT,
        ERR_END_BEFORE_START,
        ERR_DATA_CUT,
        ERR_NO_SEGMENTS
    } err_t;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] data_byte;
    } in_word_t;

    typedef struct packed {
        logic              write_valid;
        logic [ADDR_W-1:0] write_addr;
        logic [BYTE_W-1:0] write_data;
        logic              segment_done;
        logic [ADDR_W-1:0] segment_start;
        logic [ADDR_W-1:0] segment_end;
        logic              init_valid;
        logic [ADDR_W-1:0] init_addr;
        logic              run_valid;
        logic [ADDR_W-1:0] run_addr;
        logic              load_done;
        logic [2:0]        error_code;
    } out_word_t;

endpackage

FILE: src/xssl_parser.sv
// ============================================================================
// xssl_parser - segment file parser
// Holds the parse state and builds the result word for each input word.
// ============================================================================
module xssl_parser (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_fire,
    input  xssl_pkg::in_word_t        in_word,
    input  logic [xssl_pkg::ADDR_W-1:0] init_vec_addr,
    input  logic [xssl_pkg::ADDR_W-1:0] run_vec_addr,
    output xssl_pkg::out_word_t       result
);
    import xssl_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [BYTE_W-1:0]   low_hold_reg, low_hold_next;
    logic [ADDR_W-1:0]   seg_start_reg, seg_start_next;
    logic [ADDR_W-1:0]   seg_end_reg, seg_end_next;
    logic [ADDR_W-1:0]   cur_addr_reg, cur_addr_next;
    logic [ADDR_W-1:0]   init_shadow_reg, init_shadow_next;
    logic [ADDR_W-1:0]   run_shadow_reg, run_shadow_next;
    logic                any_seg_reg, any_seg_next;
    err_t                err_reg, err_next;

    logic [BYTE_W-1:0]   b;
    logic [ADDR_W-1:0]   word;
    logic [ADDR_W:0]     ia, ia1, ra, ra1, cur17, start17, end17;
    logic [ADDR_W-1:0]   init_upd, run_upd, run_clr;
    logic                seg_last, cov_init, cov_run, init_hit, run_hit;
    logic                hdr_ok, end_ok;
    logic                is_eof;

    assign b      = in_word.data_byte;
    assign is_eof = (in_word.kind == KIND_EOF);
    assign word   = {b, low_hold_reg};

    // 17-bit compares so that vector + 1 never wraps
    assign ia      = {1'b0, init_vec_addr};
    assign ia1     = ia + 17'd1;
    assign ra      = {1'b0, run_vec_addr};
    assign ra1     = ra + 17'd1;
    assign cur17   = {1'b0, cur_addr_reg};
    assign start17 = {1'b0, seg_start_reg};
    assign end17   = {1'b0, seg_end_reg};

    assign hdr_ok   = (low_hold_reg == HDR_BYTE) && (b == HDR_BYTE);
    assign end_ok   = (word >= seg_start_reg);
    assign seg_last = (cur_addr_reg == seg_end_reg);
    assign cov_init = (start17 <= ia) && (end17 >= ia1);
    assign cov_run  = (start17 <= ra) && (end17 >= ra1);

    // vector shadows after this data byte lands
    always_comb begin
        init_upd = init_shadow_reg;
        run_upd  = run_shadow_reg;
        if (cur17 == ia)  init_upd[7:0]  = b;
        if (cur17 == ia1) init_upd[15:8] = b;
        if (cur17 == ra)  run_upd[7:0]   = b;
        if (cur17 == ra1) run_upd[15:8]  = b;
    end

    assign init_hit = cov_init && (init_upd != '0);

    // init vector is consumed once reported; run bytes aliasing it read zero
    always_comb begin
        run_clr = run_upd;
        if (init_hit) begin
            if (ra == ia || ra == ia1)   run_clr[7:0]  = '0;
            if (ra1 == ia || ra1 == ia1) run_clr[15:8] = '0;
        end
    end

    assign run_hit = cov_run && (run_clr != '0);

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (is_eof) begin
            phase_next = PH_HDR0;
        end else begin
            case (phase_reg)
                PH_HDR0:      phase_next = PH_HDR1;
                PH_HDR1:      phase_next = hdr_ok ? PH_START_LO : PH_ERROR;
                PH_START_LO:  phase_next = PH_START_HI;
                PH_START_HI:  phase_next = (word == SEG_MARKER) ? PH_START2_LO : PH_END_LO;
                PH_START2_LO: phase_next = PH_START2_HI;
                PH_START2_HI: phase_next = PH_END_LO;
                PH_END_LO:    phase_next = PH_END_HI;
                PH_END_HI:    phase_next = end_ok ? PH_DATA : PH_ERROR;
                PH_DATA:      phase_next = seg_last ? PH_START_LO : PH_DATA;
                PH_ERROR:     phase_next = PH_ERROR;
                default:      phase_next = PH_HDR0;
            endcase
        end
    end

    // datapath next values and result word
    always_comb begin
        low_hold_next    = low_hold_reg;
        seg_start_next   = seg_start_reg;
        seg_end_next     = seg_end_reg;
        cur_addr_next    = cur_addr_reg;
        init_shadow_next = init_shadow_reg;
        run_shadow_next  = run_shadow_reg;
        any_seg_next     = any_seg_reg;
        err_next         = err_reg;
        result           = '0;

        if (is_eof) begin
            result.load_done = 1'b1;
            case (phase_reg)
                PH_HDR0, PH_HDR1:       result.error_code = ERR_SHORT_HDR;
                PH_START_LO, PH_START_HI,
                PH_START2_LO, PH_START2_HI:
                    result.error_code = any_seg_reg ? ERR_NONE : ERR_NO_SEGMENTS;
                PH_END_LO, PH_END_HI:   result.error_code = ERR_END_CUT;
                PH_DATA:                result.error_code = ERR_DATA_CUT;
                default:                result.error_code = err_reg;
            endcase
            low_hold_next    = '0;
            seg_start_next   = '0;
            seg_end_next     = '0;
            cur_addr_next    = '0;
            init_shadow_next = '0;
            run_shadow_next  = '0;
            any_seg_next     = 1'b0;
            err_next         = ERR_NONE;
        end else begin
            case (phase_reg)
                PH_HDR0, PH_START_LO, PH_START2_LO, PH_END_LO: begin
                    low_hold_next = b;
                end
                PH_HDR1: begin
                    if (!hdr_ok) err_next = ERR_BAD_HDR;
                end
                PH_START_HI: begin
                    if (word != SEG_MARKER) seg_start_next = word;
                end
                PH_START2_HI: begin
                    seg_start_next = word;
                end
                PH_END_HI: begin
                    seg_end_next = word;
                    if (!end_ok) begin
                        err_next = ERR_END_BEFORE_START;
                    end else begin
                        cur_addr_next    = seg_start_reg;
                        init_shadow_next = '0;
                        run_shadow_next  = '0;
                    end
                end
                PH_DATA: begin
                    result.write_valid = 1'b1;
                    result.write_addr  = cur_addr_reg;
                    result.write_data  = b;
                    init_shadow_next   = init_upd;
                    run_shadow_next    = run_upd;
                    if (seg_last) begin
                        result.segment_done  = 1'b1;
                        result.segment_start = seg_start_reg;
                        result.segment_end   = seg_end_reg;
                        if (init_hit) begin
                            result.init_valid = 1'b1;
                            result.init_addr  = init_upd;
                            init_shadow_next  = '0;
                        end
                        run_shadow_next = run_clr;
                        if (run_hit) begin
                            result.run_valid = 1'b1;
                            result.run_addr  = run_clr;
                        end
                        any_seg_next = 1'b1;
                    end else begin
                        cur_addr_next = cur_addr_reg + 16'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_HDR0;
            low_hold_reg    <= '0;
            seg_start_reg   <= '0;
            seg_end_reg     <= '0;
            cur_addr_reg    <= '0;
            init_shadow_reg <= '0;
            run_shadow_reg  <= '0;
            any_seg_reg     <= 1'b0;
            err_reg         <= ERR_NONE;
        end else if (in_fire) begin
            phase_reg       <= phase_next;
            low_hold_reg    <= low_hold_next;
            seg_start_reg   <= seg_start_next;
            seg_end_reg     <= seg_end_next;
            cur_addr_reg    <= cur_addr_next;
            init_shadow_reg <= init_shadow_next;
            run_shadow_reg  <= run_shadow_next;
            any_seg_reg     <= any_seg_next;
            err_reg         <= err_next;
        end
    end

endmodule

FILE: src/xssl_out_reg.sv
// ============================================================================
// xssl_out_reg - result output register
// One-deep result register; refills in the cycle it is drained.
// ============================================================================
module xssl_out_reg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  xssl_pkg::out_word_t  load_word,
    output logic                 can_load,
    output logic                 m_valid,
    input  logic                 m_ready,
    output xssl_pkg::out_word_t  m_data
);
    import xssl_pkg::*;

    logic      valid_reg, valid_next;
    out_word_t data_reg;

    assign can_load = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (m_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_word;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

FILE: src/xex_segment_stream_loader_core.sv
// ============================================================================
// xex_segment_stream_loader_core - segment file stream loader
// Parses an executable segment file a byte a word and emits memory writes.
// ============================================================================
// Usage:
//   s_*   : input words {kind, data_byte}. kind=0 carries a file byte,
//           kind=1 marks end of file and closes the load.
//   m_*   : one result word per input word: a memory write for each
//           segment data byte, segment bounds and init/run vectors on the
//           last byte of a segment, load_done plus error_code on end of file.
//   cfg_* : register writes (index 0 init vector address, index 1 run
//           vector address); always ready, write only while idle.
// Timing: a result appears on m_* in the cycle after its input word is taken.
// Throughput: one word per cycle while m_* is not stalled; the parser
//   is a single registered pass of byte-wide state updates and 17-bit compares.
// Stall: the result register holds while m_ready is low, and s_ready drops
//   until it drains; s_ready follows m_ready in the same cycle.
// Reset: parser returns to waiting for the FF FF header, vector addresses
//   return to 738 (init) and 736 (run), the result register empties.
// ============================================================================
module xex_segment_stream_loader_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  xssl_pkg::in_word_t             s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output xssl_pkg::out_word_t            m_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [xssl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [xssl_pkg::ADDR_W-1:0]    cfg_wdata
);
    import xssl_pkg::*;

    logic [ADDR_W-1:0] init_vec_reg, init_vec_next;
    logic [ADDR_W-1:0] run_vec_reg, run_vec_next;
    logic              in_fire;
    logic              can_load;
    out_word_t         result;

    // config registers; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_comb begin
        init_vec_next = init_vec_reg;
        run_vec_next  = run_vec_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_INIT_VEC: init_vec_next = cfg_wdata;
                REG_RUN_VEC:  run_vec_next  = cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_vec_reg <= INIT_VEC_RST;
            run_vec_reg  <= RUN_VEC_RST;
        end else begin
            init_vec_reg <= init_vec_next;
            run_vec_reg  <= run_vec_next;
        end
    end

    // take a word whenever the result register can take its result
    assign s_ready = can_load;
    assign in_fire = s_valid && can_load;

    xssl_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_fire       (in_fire),
        .in_word       (s_data),
        .init_vec_addr (init_vec_reg),
        .run_vec_addr  (run_vec_reg),
        .result        (result)
    );

    xssl_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (in_fire),
        .load_word (result),
        .can_load  (can_load),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
